// File: hdl/sprite_blit_page_framebuffer_macros.svh
// assertion helpers shared by the block
`ifndef SPRITE_BLIT_PAGE_FRAMEBUFFER_MACROS_SVH
`define SPRITE_BLIT_PAGE_FRAMEBUFFER_MACROS_SVH

`ifndef SYNTH

`define SBP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbp assertion failed");

`define SBP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbp assertion failed");

`define SBP_ASSERT_ALW(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sbp assertion failed");

`else

`define SBP_ASSERT_IMP(lbl, ante, cons)

`define SBP_ASSERT_NXT(lbl, ante, cons)

`define SBP_ASSERT_ALW(lbl, prop)

`endif

`endif

// File: hdl/sbp_pkg.sv
package sbp_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGES         = SCREEN_HEIGHT / 8;
  localparam int STORE_DEPTH   = 1024;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int MASK_W        = 16;
  localparam int MAX_W         = 128;
  localparam int MAX_H         = 64;

  typedef struct packed {
    logic              op;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic [7:0]        sprite_width;
    logic [6:0]        sprite_height;
    logic [1:0]        color_mode;
    logic              mirror;
    logic [7:0]        data_byte;
    logic              last_byte;
    logic [9:0]        read_addr;
  } in_item_t;

  typedef struct packed {
    logic [15:0] collision_mask;
    logic        blit_done;
    logic [7:0]  read_data;
  } out_item_t;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic rd_up;
    logic mod_up;
    logic mod_lo;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
  } sts_t;

endpackage

// File: hdl/sbp_if.sv
interface sbp_in_if;
  import sbp_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sbp_out_if;
  import sbp_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/sbp_ctrl.sv
`include "sprite_blit_page_framebuffer_macros.svh"

module sbp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  sbp_pkg::sts_t sts,
  output sbp_pkg::cmd_t cmd
);
  import sbp_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MOD0,
    S_MOD1,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_up  = 1'b1;
        state_next = sts.is_read ? S_FIN : S_MOD0;
      end
      S_MOD0: begin
        cmd.mod_up = 1'b1;
        state_next = S_MOD1;
      end
      S_MOD1: begin
        cmd.mod_lo = 1'b1;
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SBP_ASSERT_NXT(a_finish_shows, cmd.finish, out_valid)
  `SBP_ASSERT_ALW(a_one_mem_op, $onehot0({cmd.clear_step, cmd.rd_up, cmd.mod_up, cmd.mod_lo}))
  `SBP_ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready)
  `SBP_ASSERT_NXT(a_fin_waits, state == S_FIN && !out_free, state == S_FIN)
endmodule

// File: hdl/sbp_dp.sv
module sbp_dp (
  input  logic               clk,
  input  logic               rst,
  input  sbp_pkg::cmd_t      cmd,
  output sbp_pkg::sts_t      sts,
  input  sbp_pkg::in_item_t  in_data,
  output sbp_pkg::out_item_t out_data
);
  import sbp_pkg::*;

  localparam logic       OP_READ      = 1'b1;
  localparam logic [1:0] MODE_WHITE   = 2'd0;
  localparam logic [1:0] MODE_BLACK   = 2'd1;
  localparam logic [1:0] MODE_INVERT  = 2'd2;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_DEPTH - 1);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata;

  in_item_t          item;
  logic [6:0]        col;
  logic [2:0]        page;
  logic [MASK_W-1:0] accum;
  logic              hit_q;
  logic [ADDR_W-1:0] clr_addr;
  out_item_t         out_q;

  logic [6:0]        col_next;
  logic [2:0]        page_next;
  logic [MASK_W-1:0] accum_next;

  logic [7:0]        w_eff;
  logic [6:0]        h_eff;
  logic [7:0]        h_sum;
  logic [3:0]        rows;
  logic signed [9:0] px10;
  logic signed [9:0] py10;
  logic signed [9:0] w10;
  logic signed [9:0] h10;
  logic signed [9:0] col10;
  logic signed [9:0] sx;
  logic signed [6:0] brow;
  logic signed [6:0] brow1;
  logic [2:0]        off;
  logic              offscreen;
  logic              base_ok;
  logic              en_up;
  logic              en_lo;
  logic [ADDR_W-1:0] addr_up;
  logic [ADDR_W-1:0] addr_lo;
  logic [7:0]        up_bits;
  logic [7:0]        lo_bits;
  logic [7:0]        bits;
  logic [7:0]        merged;
  logic              hit_now;
  logic              hit_total;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;

  // clipped sprite size
  always_comb begin
    if (item.sprite_width == 8'd0) begin
      w_eff = 8'd1;
    end else if (item.sprite_width > 8'(MAX_W)) begin
      w_eff = 8'(MAX_W);
    end else begin
      w_eff = item.sprite_width;
    end
    h_eff = (item.sprite_height > 7'(MAX_H)) ? 7'(MAX_H) : item.sprite_height;
  end

  assign h_sum = {1'b0, h_eff} + 8'd7;
  assign rows  = h_sum[6:3];

  assign px10  = {{2{item.pos_x[7]}}, item.pos_x};
  assign py10  = {{2{item.pos_y[7]}}, item.pos_y};
  assign w10   = {2'b00, w_eff};
  assign h10   = {3'b000, h_eff};
  assign col10 = {3'b000, col};

  assign offscreen = ((px10 + w10) < 0) || ((py10 + h10) < 0) || (py10 > SCREEN_HEIGHT - 1);

  // floor division of the top line into page and line offset
  assign off   = item.pos_y[2:0];
  assign brow  = 7'({{2{item.pos_y[7]}}, item.pos_y[7:3]} + {4'b0000, page});
  assign brow1 = brow + 7'sd1;
  assign sx    = item.mirror ? (px10 + w10 - 10'sd1 - col10) : (px10 + col10);

  assign base_ok = !offscreen && ({1'b0, page} < rows) && ({1'b0, col} < w_eff) &&
                   (brow <= PAGES - 1) && (sx >= 0) && (sx < SCREEN_WIDTH);
  assign en_up   = base_ok && (brow >= 0);
  assign en_lo   = base_ok && (off != 3'd0) && (brow1 >= 0) && (brow1 <= PAGES - 1);

  assign addr_up = ADDR_W'({{(ADDR_W-7){1'b0}}, brow} * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(sx);
  assign addr_lo = addr_up + ADDR_W'(SCREEN_WIDTH);

  assign up_bits = item.data_byte << off;
  assign lo_bits = item.data_byte >> (4'd8 - {1'b0, off});

  // merge against the byte just read
  always_comb begin
    bits = cmd.mod_lo ? lo_bits : up_bits;
    case (item.color_mode)
      MODE_WHITE:  merged = rdata | bits;
      MODE_BLACK:  merged = rdata & ~bits;
      MODE_INVERT: merged = rdata ^ bits;
      default:     merged = rdata;
    endcase
  end

  assign hit_now   = ((cmd.mod_up && en_up) || (cmd.mod_lo && en_lo)) && ((rdata & bits) != 8'h00);
  assign hit_total = hit_q || hit_now;

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = 8'h00;
    if (cmd.clear_step) begin
      we = 1'b1;
    end else if (cmd.mod_up) begin
      we    = en_up;
      waddr = addr_up;
      wdata = merged;
    end else if (cmd.mod_lo) begin
      we    = en_lo;
      waddr = addr_lo;
      wdata = merged;
    end
  end

  assign re = cmd.rd_up || cmd.mod_up;

  always_comb begin
    if (cmd.rd_up) begin
      raddr = (item.op == OP_READ) ? item.read_addr : addr_up;
    end else begin
      raddr = addr_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // bitmap counters and collision mask
  always_comb begin
    col_next   = col;
    page_next  = page;
    accum_next = accum;
    if (hit_total && (col[6:4] == 3'd0)) begin
      accum_next = accum | (MASK_W'(1) << col[3:0]);
    end
    if (item.last_byte) begin
      col_next   = 7'd0;
      page_next  = 3'd0;
    end else if (({1'b0, col} + 8'd1) >= w_eff) begin
      col_next  = 7'd0;
      page_next = page + 3'd1;
    end else begin
      col_next = col + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= 7'd0;
      page     <= 3'd0;
      accum    <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.finish && (item.op != OP_READ)) begin
        col   <= col_next;
        page  <= page_next;
        accum <= item.last_byte ? '0 : accum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item  <= in_data;
      hit_q <= 1'b0;
    end else if (cmd.mod_up || cmd.mod_lo) begin
      hit_q <= hit_total;
    end
    if (cmd.finish) begin
      if (item.op == OP_READ) begin
        out_q.collision_mask <= '0;
        out_q.blit_done      <= 1'b0;
        out_q.read_data      <= rdata;
      end else begin
        out_q.collision_mask <= item.last_byte ? accum_next : '0;
        out_q.blit_done      <= item.last_byte;
        out_q.read_data      <= 8'h00;
      end
    end
  end

  assign sts.clr_last = (clr_addr == CLR_LAST);
  assign sts.is_read  = (item.op == OP_READ);
  assign out_data     = out_q;
endmodule

// File: hdl/sprite_blit_page_framebuffer.sv
// channel   dir   request contents
// in_ch     in    sprite column byte to blit, or framebuffer read address
// out_ch    out   collision mask and done flag, or framebuffer byte
//
// after reset the frame store is swept to zero, one byte a cycle, with
// in_ch.ready low
// after acceptance a blit steps through upper page read, upper write with lower
// read, lower write, all on one single-port-write frame memory
// a read steps through address, registered memory data, result
// a result waiting on out_ch does not stop the next request being accepted;
// the block holds only its own finished result until out_ch takes the previous
module sprite_blit_page_framebuffer (
  input logic       clk,
  input logic       rst,
  sbp_in_if.sink    in_ch,
  sbp_out_if.source out_ch
);
  import sbp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_ch.data),
    .out_data (out_ch.data)
  );
endmodule

// File: tb/sprite_blit_page_framebuffer_tb.sv
module sprite_blit_page_framebuffer_tb;
  import sbp_pkg::*;

  localparam logic OP_BLIT = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 250;
  localparam int REPORT_CAP = 40;
  localparam int IN_W = $bits(in_item_t);

  typedef enum logic [1:0] {
    MODE_WHITE  = 2'd0,
    MODE_BLACK  = 2'd1,
    MODE_INVERT = 2'd2,
    MODE_NONE   = 2'd3
  } colour_t;

  typedef struct {
    in_item_t req;
    int       gap;
    bit       drain;
    bit       hold;
  } queued_req_t;

  logic clk = 1'b0;
  logic rst;

  sbp_in_if  in_ch();
  sbp_out_if out_ch();

  sprite_blit_page_framebuffer dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // shadow of the block state
  logic [7:0]  screen_copy [STORE_DEPTH];
  logic [6:0]  col_next;
  logic [2:0]  page_next;
  logic [15:0] mask_acc;

  queued_req_t request_queue[$];
  out_item_t   due_results[$];

  bit  drain_next, hold_next;
  int  items_made;
  int  errors, checked;
  int  blits_sent, reads_sent, sprites_closed, sprites_hit;

  logic in_fire, out_fire;
  int   gap_count, hold_asks;
  bit   offer;
  queued_req_t cur;
  int   stall_left, hold_seen, rx_taken;
  bit   rx_calm;
  out_item_t want;
  int   idle_cycles;

  function automatic bit merge_into(input int pg, input int x, input logic [7:0] bits,
                                    input colour_t mode);
    logic [9:0] addr;
    logic [7:0] old;
    addr = 10'(pg * SCREEN_WIDTH + x);
    old = screen_copy[addr];
    case (mode)
      MODE_WHITE:  screen_copy[addr] = old | bits;
      MODE_BLACK:  screen_copy[addr] = old & ~bits;
      MODE_INVERT: screen_copy[addr] = old ^ bits;
      default: ;
    endcase
    return (old & bits) != 8'd0;
  endfunction

  function automatic out_item_t paint_byte(input in_item_t r);
    int px, py, w, h, col, pg, rows, off, brow, sx;
    bit hit, offscreen;
    out_item_t res;
    res = '0;
    if (r.op == OP_READ) begin
      reads_sent++;
      res.read_data = screen_copy[r.read_addr];
      return res;
    end
    blits_sent++;
    px = $signed(r.pos_x);
    py = $signed(r.pos_y);
    w = r.sprite_width;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    h = r.sprite_height;
    if (h > MAX_H) h = MAX_H;
    col = col_next;
    pg = page_next;
    rows = (h + 7) / 8;
    hit = 1'b0;
    offscreen = (px + w < 0) || (py + h < 0) || (py > SCREEN_HEIGHT - 1);
    if (!offscreen && pg < rows && col < w) begin
      off = (py + 128) & 7;
      brow = (py + 128 - off) / 8 - 16 + pg;
      sx = r.mirror ? px + w - 1 - col : px + col;
      if (brow <= PAGES - 1 && sx >= 0 && sx < SCREEN_WIDTH) begin
        if (brow >= 0)
          hit |= merge_into(brow, sx, 8'(r.data_byte << off), colour_t'(r.color_mode));
        if (off != 0 && brow + 1 >= 0 && brow + 1 <= PAGES - 1)
          hit |= merge_into(brow + 1, sx, 8'(r.data_byte >> (8 - off)),
                            colour_t'(r.color_mode));
      end
    end
    if (hit && col < MASK_W) mask_acc[col] = 1'b1;
    if (r.last_byte) begin
      res.collision_mask = mask_acc;
      res.blit_done = 1'b1;
      sprites_closed++;
      if (mask_acc != 16'd0) sprites_hit++;
      col_next = '0;
      page_next = '0;
      mask_acc = '0;
    end else if (col + 1 >= w) begin
      col_next = '0;
      page_next = page_next + 3'd1;
    end else begin
      col_next = 7'(col + 1);
    end
    return res;
  endfunction

  function automatic in_item_t blit_req(input int px, input int py, input int w, input int h,
                                        input colour_t mode, input bit mir,
                                        input int data, input bit last);
    in_item_t r;
    r.op = OP_BLIT;
    r.pos_x = 8'(px);
    r.pos_y = 8'(py);
    r.sprite_width = 8'(w);
    r.sprite_height = 7'(h);
    r.color_mode = mode;
    r.mirror = mir;
    r.data_byte = 8'(data);
    r.last_byte = last;
    r.read_addr = 10'($urandom);
    return r;
  endfunction

  function automatic in_item_t read_req(input int addr);
    in_item_t r;
    r = in_item_t'(IN_W'({$urandom, $urandom}));
    r.op = OP_READ;
    r.read_addr = 10'(addr);
    return r;
  endfunction

  task automatic push_req(input in_item_t r, input int gap_max);
    queued_req_t q;
    q.req = r;
    q.gap = $urandom_range(0, gap_max);
    q.drain = drain_next;
    q.hold = hold_next;
    drain_next = 1'b0;
    hold_next = 1'b0;
    request_queue.push_back(q);
    items_made++;
  endtask

  task automatic push_sprite(input int px, input int py, input int w, input int h,
                             input colour_t mode, input bit mir, input int n,
                             input int gap_max, input bit chaos, input bit mix_reads);
    in_item_t r;
    int data;
    for (int i = 0; i < n; i++) begin
      if (mix_reads && $urandom_range(0, 11) == 0)
        push_req(read_req($urandom_range(0, STORE_DEPTH - 1)), gap_max);
      if ($urandom_range(0, 3) == 0) data = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      else data = $urandom_range(0, 255);
      r = blit_req(px, py, w, h, mode, mir, data, i == n - 1);
      if (chaos) begin
        r = in_item_t'(IN_W'({$urandom, $urandom}));
        r.op = OP_BLIT;
        r.last_byte = (i == n - 1);
      end
      push_req(r, gap_max);
    end
  endtask

  task automatic note_mismatch(input string what, input int got, input int exp_val);
    errors++;
    if (errors <= REPORT_CAP)
      $display("mismatch at result %0d: %s got %0h expected %0h", checked, what, got, exp_val);
  endtask

  // sampled handshakes and prediction on acceptance
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) due_results.push_back(paint_byte(in_ch.data));
    in_fire <= !rst && in_ch.valid && in_ch.ready;
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      gap_count = 0;
    end else if (!in_ch.valid || in_fire) begin
      offer = 1'b0;
      if (request_queue.size() != 0) begin
        if (gap_count < request_queue[0].gap) gap_count++;
        else if (!(request_queue[0].drain && due_results.size() != 0)) offer = 1'b1;
      end
      if (offer) begin
        cur = request_queue.pop_front();
        gap_count = 0;
        in_ch.data <= cur.req;
        if (cur.hold) hold_asks <= hold_asks + 1;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver with its own stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        stall_left = HOLD_CYCLES;
      end else if (out_fire) begin
        rx_taken++;
        if (rx_taken % 60 == 0) rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(0, 16);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      checked++;
      if (due_results.size() == 0) begin
        note_mismatch("unexpected result", int'(out_ch.data), 0);
      end else begin
        want = due_results.pop_front();
        if (out_ch.data.collision_mask !== want.collision_mask)
          note_mismatch("collision_mask", out_ch.data.collision_mask, want.collision_mask);
        if (out_ch.data.blit_done !== want.blit_done)
          note_mismatch("blit_done", out_ch.data.blit_done, want.blit_done);
        if (out_ch.data.read_data !== want.read_data)
          note_mismatch("read_data", out_ch.data.read_data, want.read_data);
      end
    end
    out_fire <= !rst && out_ch.valid && out_ch.ready;
  end

  // watchdog on lack of progress
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no request moved for %0d cycles", IDLE_LIMIT);
      $display("sprite_blit_page_framebuffer_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int w, h, rows, nominal, n, gap_max, kind, px, py;
    bit mid_drain_done;
    colour_t mode;

    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    in_fire = 1'b0;
    out_fire = 1'b0;
    idle_cycles = 0;
    hold_asks = 0;
    hold_seen = 0;
    stall_left = 0;
    rx_calm = 1'b0;
    mid_drain_done = 1'b0;
    col_next = '0;
    page_next = '0;
    mask_acc = '0;
    foreach (screen_copy[i]) screen_copy[i] = 8'h00;

    // directed part
    push_req(read_req(0), 3);
    push_req(read_req(STORE_DEPTH - 1), 3);
    push_req(blit_req(0, 0, 1, 8, MODE_WHITE, 1'b0, 8'hFF, 1'b1), 3);
    push_req(blit_req(0, 0, 1, 8, MODE_INVERT, 1'b0, 8'h0F, 1'b1), 3);
    push_req(blit_req(-128, -128, 1, 8, MODE_WHITE, 1'b0, 8'hFF, 1'b1), 3);
    push_req(blit_req(127, 127, 128, 64, MODE_WHITE, 1'b1, 8'hFF, 1'b1), 3);
    push_req(blit_req(5, -3, 2, 8, MODE_WHITE, 1'b0, 8'hAA, 1'b0), 3);
    push_req(blit_req(5, -3, 2, 8, MODE_WHITE, 1'b0, 8'h55, 1'b1), 3);
    push_req(blit_req(126, 60, 4, 8, MODE_WHITE, 1'b1, 8'hFF, 1'b0), 3);
    push_req(blit_req(126, 60, 4, 8, MODE_WHITE, 1'b1, 8'h81, 1'b0), 3);
    push_req(blit_req(126, 60, 4, 8, MODE_WHITE, 1'b1, 8'h00, 1'b0), 3);
    push_req(blit_req(126, 60, 4, 8, MODE_WHITE, 1'b1, 8'hFF, 1'b1), 3);
    push_req(blit_req(10, 10, 0, 0, MODE_NONE, 1'b0, 8'hFF, 1'b1), 3);
    push_req(blit_req(0, 0, 255, 127, MODE_BLACK, 1'b1, 8'h55, 1'b1), 3);
    push_req(blit_req(20, 8, 1, 8, MODE_WHITE, 1'b0, 8'h3C, 1'b0), 3);
    push_req(blit_req(20, 8, 1, 8, MODE_WHITE, 1'b0, 8'hC3, 1'b1), 3);
    push_req(blit_req(0, 0, 1, 8, MODE_NONE, 1'b0, 8'hFF, 1'b1), 3);
    push_req(read_req(0), 3);
    push_req(read_req(SCREEN_WIDTH - 1), 3);
    push_req(read_req(STORE_DEPTH - 2), 3);
    push_req(read_req(SCREEN_WIDTH + 20), 3);

    // back-pressure: sender keeps going while the receiver holds off
    drain_next = 1'b1;
    hold_next = 1'b1;
    push_sprite(10, 3, 24, 8, MODE_WHITE, 1'b0, 24, 0, 1'b0, 1'b0);

    // random sprites, mostly well formed
    while (items_made < 830) begin
      if (!mid_drain_done && items_made > 420) begin
        drain_next = 1'b1;
        mid_drain_done = 1'b1;
      end
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
      case ($urandom_range(0, 7))
        0, 1, 2, 3, 4: w = $urandom_range(1, 12);
        5, 6:          w = $urandom_range(13, 24);
        default:       w = $urandom_range(25, MAX_W);
      endcase
      if (w > 24) h = $urandom_range(1, 8);
      else if (w <= 4 && $urandom_range(0, 2) == 0) h = $urandom_range(1, MAX_H);
      else h = $urandom_range(1, 24);
      rows = (h + 7) / 8;
      nominal = w * rows;
      if ($urandom_range(0, 5) == 0) begin
        px = $urandom_range(0, 255) - 128;
        py = $urandom_range(0, 255) - 128;
      end else begin
        px = $urandom_range(0, 151) - 24;
        py = $urandom_range(0, 80) - 12;
      end
      mode = ($urandom_range(0, 7) == 0) ? MODE_NONE : colour_t'($urandom_range(0, 2));
      kind = $urandom_range(0, 9);
      case (kind)
        0:       n = $urandom_range(1, nominal);
        1:       n = nominal + $urandom_range(1, 8);
        2:       n = $urandom_range(1, 6);
        default: n = nominal;
      endcase
      push_sprite(px, py, w, h, mode, $urandom_range(0, 1), n, gap_max, kind == 2, 1'b1);
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 4))
          push_req(read_req($urandom_range(0, STORE_DEPTH - 1)), gap_max);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (request_queue.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d sprite bytes and %0d reads; %0d sprites closed, %0d with collisions",
             blits_sent, reads_sent, sprites_closed, sprites_hit);
    $display("%0d results checked, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("sprite_blit_page_framebuffer_tb passed");
    end else begin
      $display("sprite_blit_page_framebuffer_tb failed");
    end
    $finish;
  end

endmodule
